/* hw/rtl/mtpfw_pkg.sv */
package mtpfw_pkg;

	// field and register widths
	localparam int ADDR_W     = 23;
	localparam int DATA_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int DIM_W      = 12;
	localparam int BLKS_W     = 9;
	localparam int CELL_W     = 2;
	localparam int ORG_W      = 8;
	localparam int PROD_W     = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_ACROSS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_DOWN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_CELLS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_VERT_CELLS    = 3'd5;

	// register reset values
	localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH   = 12'd640;
	localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT  = 12'd480;
	localparam logic [BLKS_W-1:0] RST_BLOCKS_ACROSS = 9'd80;
	localparam logic [BLKS_W-1:0] RST_BLOCKS_DOWN   = 9'd60;
	localparam logic [CELL_W-1:0] RST_HORIZ_CELLS   = 2'd2;
	localparam logic [CELL_W-1:0] RST_VERT_CELLS    = 2'd2;

	// plane bases for the reset picture size
	localparam logic [PROD_W-1:0] RST_LUMA_AREA = 24'd307200;
	localparam logic [ADDR_W-1:0] RST_V_BASE    = 23'd460800;

	localparam logic [DIM_W-1:0]  MAX_WIDTH  = 12'd2048;
	localparam logic [BLKS_W-1:0] MAX_BLOCKS = 9'd256;

	// one accepted sample, decoded
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              luma;
		logic              en;
		logic              two;
		logic              cr;
		logic [2:0]        row;
		logic [2:0]        col;
		logic              cx;
		logic              cy;
		logic [ORG_W-1:0]  lbx;
		logic [ORG_W-1:0]  lby;
		logic              fe;
	} item_t;

	// origin wrap result of the fast path
	typedef struct packed {
		logic             ok;
		logic [ORG_W-1:0] val;
	} wrap_t;

	// (sum mod n) for sum below three times n, else ok is low
	function automatic wrap_t wrap_fast(logic [BLKS_W-1:0] sum, logic [BLKS_W-1:0] n);
		logic [10:0] s;
		logic [10:0] n1;
		logic [10:0] n2;
		logic [10:0] n3;
		logic [10:0] d1;
		logic [10:0] d2;
		wrap_t       r;
		s  = {2'b00, sum};
		n1 = {2'b00, n};
		n2 = {1'b0, n, 1'b0};
		n3 = n2 + n1;
		d1 = s - n1;
		d2 = s - n2;
		r.ok = 1'b1;
		if (s < n1) begin
			r.val = s[ORG_W-1:0];
		end else if (s < n2) begin
			r.val = d1[ORG_W-1:0];
		end else if (s < n3) begin
			r.val = d2[ORG_W-1:0];
		end else begin
			r.ok  = 1'b0;
			r.val = '0;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/mcu_to_planar_frame_writer.sv */
// a sample passes the input register, the product register and the output register on its way out
// throughput: one sample per cycle when nothing stalls; a kept chroma sample of a two-row MCU
// holds the output register for two writes; an MCU advance that lands at three or more
// times the block count stalls input while the serial remainder unit runs
// reset: asynchronous, clears the block counters, the MCU origin and all pipeline
// valids; configuration returns to 640x480, 80x60 blocks, 2x2 cells
module mcu_to_planar_frame_writer import mtpfw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [DATA_W-1:0]     sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  write_enable,
	output logic [ADDR_W-1:0]     write_address,
	output logic [DATA_W-1:0]     write_data,
	output logic                  frame_done,
	output logic                  last_of_run
);

	localparam logic [1:0] FIX_IDLE = 2'd0;
	localparam logic [1:0] FIX_X    = 2'd1;
	localparam logic [1:0] FIX_Y    = 2'd2;
	localparam logic [3:0] FIX_STEPS = 4'd8;
	localparam logic [5:0] PIX_LAST  = 6'd63;

	// configuration registers
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [BLKS_W-1:0] across_q;
	logic [BLKS_W-1:0] down_q;
	logic [CELL_W-1:0] horiz_q;
	logic [CELL_W-1:0] vert_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			across_q <= RST_BLOCKS_ACROSS;
			down_q   <= RST_BLOCKS_DOWN;
			horiz_q  <= RST_HORIZ_CELLS;
			vert_q   <= RST_VERT_CELLS;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:   width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT:  height_q <= cfg_data;
				CFG_BLOCKS_ACROSS: across_q <= cfg_data[BLKS_W-1:0];
				CFG_BLOCKS_DOWN:   down_q   <= cfg_data[BLKS_W-1:0];
				CFG_HORIZ_CELLS:   horiz_q  <= cfg_data[CELL_W-1:0];
				CFG_VERT_CELLS:    vert_q   <= cfg_data[CELL_W-1:0];
				default: ;
			endcase
		end
	end

	// saturated configuration
	logic              h2;
	logic              v2;
	logic [BLKS_W-1:0] nbx_c;
	logic [BLKS_W-1:0] nby_c;
	logic [DIM_W-1:0]  w_c;
	logic [2:0]        nl_c;

	always_comb begin
		h2    = horiz_q[1];
		v2    = vert_q[1];
		nbx_c = (across_q == '0) ? 9'd1 : ((across_q > MAX_BLOCKS) ? MAX_BLOCKS : across_q);
		nby_c = (down_q == '0) ? 9'd1 : ((down_q > MAX_BLOCKS) ? MAX_BLOCKS : down_q);
		w_c   = (width_q > MAX_WIDTH) ? MAX_WIDTH : width_q;
		nl_c  = (h2 && v2) ? 3'd4 : ((h2 || v2) ? 3'd2 : 3'd1);
	end

	// plane bases, registered behind the configuration
	logic [PROD_W-1:0] wh_q;
	logic [ADDR_W-1:0] basev_q;
	logic [PROD_W:0]   basev_sum;

	assign basev_sum = {1'b0, wh_q} + {2'b00, wh_q[PROD_W-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wh_q    <= RST_LUMA_AREA;
			basev_q <= RST_V_BASE;
		end else begin
			wh_q    <= {12'd0, w_c} * {12'd0, height_q};
			basev_q <= basev_sum[ADDR_W-1:0];
		end
	end

	// block position state
	logic [5:0]       pix_q;
	logic [2:0]       blk_q;
	logic [ORG_W-1:0] lbx_q;
	logic [ORG_W-1:0] lby_q;
	logic [1:0]       fix_st_q;
	logic [8:0]       rem_q;
	logic [8:0]       dvd_q;
	logic [3:0]       cnt_q;

	logic              in_accept;
	logic              fix_busy;
	logic              mcu_end;
	logic [BLKS_W-1:0] sum_x;
	logic [BLKS_W-1:0] sum_y;
	wrap_t             wx;
	wrap_t             wy;

	// decode of the sample at the input
	item_t            item_in;
	logic             keep;
	logic [2:0]       col;

	always_comb begin
		col          = pix_q[2:0];
		keep         = h2 || !col[0];
		item_in.data = sample;
		item_in.luma = blk_q < nl_c;
		item_in.en   = item_in.luma || keep;
		item_in.two  = !item_in.luma && keep && v2;
		item_in.cr   = blk_q != nl_c;
		item_in.row  = pix_q[5:3];
		item_in.col  = (h2 || item_in.luma) ? col : {1'b0, col[2:1]};
		item_in.cx   = item_in.luma && h2 && blk_q[0];
		item_in.cy   = item_in.luma && (h2 ? blk_q[1] : blk_q[0]);
		item_in.lbx  = lbx_q;
		item_in.lby  = lby_q;
		mcu_end      = (pix_q == PIX_LAST) && (blk_q > nl_c);
		sum_x        = {1'b0, lbx_q} + (h2 ? 9'd2 : 9'd1);
		sum_y        = {1'b0, lby_q} + (v2 ? 9'd2 : 9'd1);
		wx           = wrap_fast(sum_x, nbx_c);
		wy           = wrap_fast(sum_y, nby_c);
		item_in.fe   = mcu_end && wx.ok && (wx.val == '0) && wy.ok && (wy.val == '0);
	end

	// serial remainder for origins outside the grid
	logic [BLKS_W-1:0] dvs;
	logic [9:0]        trial;
	logic [9:0]        tdiff;
	logic [8:0]        rem_next;
	logic [ORG_W-1:0]  fix_res;
	logic              fix_set_fe;

	always_comb begin
		fix_busy = fix_st_q != FIX_IDLE;
		dvs      = (fix_st_q == FIX_Y) ? nby_c : nbx_c;
		trial    = {rem_q, dvd_q[8]};
		tdiff    = trial - {1'b0, dvs};
		rem_next = (trial >= {1'b0, dvs}) ? tdiff[8:0] : trial[8:0];
		fix_res  = rem_next[ORG_W-1:0];
		fix_set_fe = ((fix_st_q == FIX_X) && (cnt_q == '0) && (fix_res == '0) && wy.ok
		              && (wy.val == '0))
		          || ((fix_st_q == FIX_Y) && (cnt_q == '0) && (fix_res == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q    <= '0;
			blk_q    <= '0;
			lbx_q    <= '0;
			lby_q    <= '0;
			fix_st_q <= FIX_IDLE;
			rem_q    <= '0;
			dvd_q    <= '0;
			cnt_q    <= '0;
		end else begin
			unique case (fix_st_q)
				FIX_IDLE: begin
					if (in_accept) begin
						pix_q <= pix_q + 6'd1;
						if (mcu_end) begin
							blk_q <= '0;
							if (!wx.ok) begin
								fix_st_q <= FIX_X;
								rem_q    <= '0;
								dvd_q    <= sum_x;
								cnt_q    <= FIX_STEPS;
							end else begin
								lbx_q <= wx.val;
								if (wx.val == '0) begin
									if (wy.ok) begin
										lby_q <= wy.val;
									end else begin
										fix_st_q <= FIX_Y;
										rem_q    <= '0;
										dvd_q    <= sum_y;
										cnt_q    <= FIX_STEPS;
									end
								end
							end
						end else if (pix_q == PIX_LAST) begin
							blk_q <= blk_q + 3'd1;
						end
					end
				end
				FIX_X: begin
					if (cnt_q != '0) begin
						rem_q <= rem_next;
						dvd_q <= {dvd_q[7:0], 1'b0};
						cnt_q <= cnt_q - 4'd1;
					end else begin
						lbx_q <= fix_res;
						if ((fix_res == '0) && !wy.ok) begin
							fix_st_q <= FIX_Y;
							rem_q    <= '0;
							dvd_q    <= sum_y;
							cnt_q    <= FIX_STEPS;
						end else begin
							fix_st_q <= FIX_IDLE;
							if (fix_res == '0) begin
								lby_q <= wy.val;
							end
						end
					end
				end
				FIX_Y: begin
					if (cnt_q != '0) begin
						rem_q <= rem_next;
						dvd_q <= {dvd_q[7:0], 1'b0};
						cnt_q <= cnt_q - 4'd1;
					end else begin
						lby_q    <= fix_res;
						fix_st_q <= FIX_IDLE;
					end
				end
				default: fix_st_q <= FIX_IDLE;
			endcase
		end
	end

	// pipeline flow control
	logic item_v_s1;
	logic v_s2;
	logic out_v_q;
	logic pend_q;
	logic out_take;
	logic out_free;
	logic s2_move;
	logic s1_move;

	always_comb begin
		out_take  = out_v_q && !out_stall;
		out_free  = !out_v_q || (out_take && !pend_q);
		s2_move   = v_s2 && out_free;
		s1_move   = item_v_s1 && !fix_busy && (!v_s2 || s2_move);
		in_stall  = fix_busy || (item_v_s1 && !s1_move);
		in_accept = in_valid && !in_stall;
	end

	// input register
	item_t item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (in_accept) begin
			item_v_s1 <= 1'b1;
		end else if (s1_move) begin
			item_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= item_in;
		end else if (fix_set_fe) begin
			item_s1.fe <= 1'b1;
		end
	end

	// row products: luma row times stride, or chroma MCU row times width
	logic [8:0]        lbyc;
	logic [DIM_W-1:0]  mul_a;
	logic [DIM_W-1:0]  mul_b;

	always_comb begin
		lbyc  = {1'b0, item_s1.lby} + {8'd0, item_s1.cy};
		mul_a = item_s1.luma ? {lbyc, item_s1.row} : {4'd0, item_s1.lby};
		mul_b = item_s1.luma ? {3'd0, nbx_c} : w_c;
	end

	logic [PROD_W-1:0] prod_s2;
	logic [11:0]       rownb_s2;
	logic [8:0]        lbxc_s2;
	logic [ORG_W-1:0]  lbx_s2;
	logic [DATA_W-1:0] data_s2;
	logic [2:0]        col_s2;
	logic              luma_s2;
	logic              en_s2;
	logic              two_s2;
	logic              cr_s2;
	logic              fe_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_move) begin
			v_s2 <= 1'b1;
		end else if (s2_move) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			prod_s2  <= {12'd0, mul_a} * {12'd0, mul_b};
			rownb_s2 <= {9'd0, item_s1.row} * {3'd0, nbx_c};
			lbxc_s2  <= {1'b0, item_s1.lbx} + {8'd0, item_s1.cx};
			lbx_s2   <= item_s1.lbx;
			data_s2  <= item_s1.data;
			col_s2   <= item_s1.col;
			luma_s2  <= item_s1.luma;
			en_s2    <= item_s1.en;
			two_s2   <= item_s1.two;
			cr_s2    <= item_s1.cr;
			fe_s2    <= item_s1.fe;
		end
	end

	// final address sum
	logic [ADDR_W-1:0] luma_addr;
	logic [ADDR_W-1:0] chroma_addr;
	logic [ADDR_W-1:0] chroma_base;
	logic [ADDR_W-1:0] next_addr;
	logic [ADDR_W-1:0] row_step;

	always_comb begin
		chroma_base = cr_s2 ? basev_q : wh_q[ADDR_W-1:0];
		luma_addr   = {prod_s2[ADDR_W-4:0], 3'b000}
		            + {11'd0, lbxc_s2, 3'b000}
		            + {20'd0, col_s2};
		chroma_addr = chroma_base
		            + {prod_s2[ADDR_W-3:0], 2'b00}
		            + {13'd0, lbx_s2, 2'b00}
		            + {9'd0, rownb_s2, 2'b00}
		            + {20'd0, col_s2};
		next_addr   = luma_s2 ? luma_addr : chroma_addr;
		row_step    = {9'd0, w_c, 2'b00};
	end

	// output register; a second chroma row write steps the address by four widths
	logic              we_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] data_q;
	logic              fe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (s2_move) begin
			out_v_q <= 1'b1;
			pend_q  <= en_s2 && two_s2;
		end else if (out_take) begin
			if (pend_q) begin
				pend_q <= 1'b0;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			we_q   <= en_s2;
			addr_q <= en_s2 ? next_addr : '0;
			data_q <= en_s2 ? data_s2 : '0;
			fe_q   <= fe_s2;
		end else if (out_take && pend_q) begin
			addr_q <= addr_q + row_step;
		end
	end

	assign out_valid     = out_v_q;
	assign write_enable  = we_q;
	assign write_address = addr_q;
	assign write_data    = data_q;
	assign last_of_run   = !pend_q;
	assign frame_done    = fe_q && !pend_q;

endmodule

/* hw/rtl/mtpfw_checker.sv */
module mtpfw_checker import mtpfw_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic              write_enable,
	input logic [ADDR_W-1:0] write_address,
	input logic [DATA_W-1:0] write_data,
	input logic              frame_done,
	input logic              last_of_run
);

	// frame end only marks the closing result of a sample
	a_frame_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> last_of_run)
		else $error("frame_done without last_of_run");

	// a dropped chroma sample is a single blank result
	a_drop_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> last_of_run && (write_address == '0)
		&& (write_data == '0))
		else $error("disabled result is not blank");

	// the second row write follows at once with the same sample
	a_second_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid && write_enable
		&& $stable(write_data))
		else $error("second chroma write missing");

	// a stalled request holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(write_address)
		&& $stable(last_of_run))
		else $error("stalled request changed");

endmodule

bind mcu_to_planar_frame_writer mtpfw_checker u_mtpfw_checker (.*);

/* bench/mcu_to_planar_frame_writer_test.sv */
module mcu_to_planar_frame_writer_test;
	import mtpfw_pkg::*;

	// one frame buffer write as it should leave the block
	typedef struct {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic              done;
		logic              last;
	} fb_write_t;

	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_TARGET = 2000;
	localparam int TAIL_ITEMS    = 150;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [DATA_W-1:0]     sample = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  write_enable;
	logic [ADDR_W-1:0]     write_address;
	logic [DATA_W-1:0]     write_data;
	logic                  frame_done;
	logic                  last_of_run;

	// shadow of the configuration registers
	logic [DIM_W-1:0]  pic_width;
	logic [DIM_W-1:0]  pic_height;
	logic [BLKS_W-1:0] blk_across;
	logic [BLKS_W-1:0] blk_down;
	logic [CELL_W-1:0] cells_h;
	logic [CELL_W-1:0] cells_v;

	// shadow of the stream position
	logic [5:0]       pix_idx;
	logic [2:0]       blk_idx;
	logic [ORG_W-1:0] org_x;
	logic [ORG_W-1:0] org_y;

	logic [DATA_W-1:0] sample_queue[$];
	fb_write_t         pending_writes[$];
	fb_write_t         want;

	logic in_taken = 1'b0;
	logic idling_on = 1'b1;
	logic hold_go = 1'b0;
	logic rx_hold = 1'b0;
	int   tx_gap = 0;
	int   rx_gap = 0;
	int   pushed_count = 0;
	int   accepted_count = 0;
	int   writes_seen = 0;
	int   drops_seen = 0;
	int   frames_seen = 0;
	int   config_count = 0;
	int   error_count = 0;

	mcu_to_planar_frame_writer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.write_enable  (write_enable),
		.write_address (write_address),
		.write_data    (write_data),
		.frame_done    (frame_done),
		.last_of_run   (last_of_run)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// frame buffer writes caused by one sample, from the shadow state
	function automatic void predict_writes(input logic [DATA_W-1:0] s);
		longint unsigned h, v, nbx, nby, w, ht, col, row, b, nl, lbx, lby, stp, base, cy, p;
		fb_write_t       wr[2];
		int              n;
		logic            wrap;
		h    = (cells_h < 1) ? 1 : ((cells_h > 2) ? 2 : cells_h);
		v    = (cells_v < 1) ? 1 : ((cells_v > 2) ? 2 : cells_v);
		nbx  = (blk_across < 1) ? 1 : ((blk_across > 256) ? 256 : blk_across);
		nby  = (blk_down < 1) ? 1 : ((blk_down > 256) ? 256 : blk_down);
		w    = (pic_width > 2048) ? 2048 : pic_width;
		ht   = pic_height;
		p    = pix_idx;
		col  = p % 8;
		row  = p / 8;
		b    = blk_idx;
		nl   = h * v;
		lbx  = org_x;
		lby  = org_y;
		wrap = 1'b0;
		n    = 0;
		for (int k = 0; k < 2; k++)
			wr[k] = '{en: 1'b0, addr: '0, data: '0, done: 1'b0, last: 1'b0};

		if (b < nl) begin
			// luma goes to its raster address
			wr[0].en   = 1'b1;
			wr[0].addr = ADDR_W'(((lby + b / h) * 8 + row) * 8 * nbx + (lbx + b % h) * 8 + col);
			wr[0].data = s;
			n = 1;
		end else begin
			stp = 3 - h;
			if (col % stp != 0) begin
				// dropped chroma column
				n = 1;
			end else begin
				base = (b == nl) ? w * ht : (w * ht * 3) >> 1;
				for (cy = 0; cy < v; cy++) begin
					wr[n].en   = 1'b1;
					wr[n].addr = ADDR_W'(base + (((lby + cy) * 8 * w) >> 1) + ((lbx * 8) >> 1)
						+ ((row * 8 * nbx) >> 1) + col / stp);
					wr[n].data = s;
					n++;
				end
			end
		end

		// advance pixel, block and MCU origin
		p++;
		if (p >= 64) begin
			p = 0;
			if (b >= nl + 1) begin
				b   = 0;
				lbx = (lbx + h) % nbx;
				if (lbx == 0) begin
					lby = (lby + v) % nby;
					if (lby == 0)
						wrap = 1'b1;
				end
			end else begin
				b++;
			end
		end
		pix_idx = p[5:0];
		blk_idx = b[2:0];
		org_x   = lbx[ORG_W-1:0];
		org_y   = lby[ORG_W-1:0];

		wr[n-1].last = 1'b1;
		wr[n-1].done = wrap;
		for (int k = 0; k < n; k++)
			pending_writes.push_back(wr[k]);
	endfunction

	// sender: holds a request until taken, random bursts of idle cycles
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				in_valid <= 1'b0;
			end else if (idling_on && $urandom_range(0, 9) == 0) begin
				tx_gap <= $urandom_range(0, 4);
				in_valid <= 1'b0;
			end else if (sample_queue.size() != 0) begin
				in_valid <= 1'b1;
				sample <= sample_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stall bursts, or the long hold-off
	always @(negedge clk) begin
		if (rx_hold) begin
			out_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			out_stall <= 1'b1;
		end else if (idling_on && $urandom_range(0, 7) == 0) begin
			rx_gap <= $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// long receiver hold-off so the pipe backs up into the input
	initial begin
		wait (hold_go);
		@(negedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold <= 1'b0;
	end

	// check results first, then predict for the sample taken at this edge
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_writes.size() == 0) begin
				report_mismatch("result with no write expected");
			end else begin
				want = pending_writes.pop_front();
				if (write_enable !== want.en)
					report_mismatch($sformatf("write_enable %b, expected %b",
						write_enable, want.en));
				if (write_address !== want.addr)
					report_mismatch($sformatf("write_address 0x%06h, expected 0x%06h",
						write_address, want.addr));
				if (write_data !== want.data)
					report_mismatch($sformatf("write_data 0x%02h, expected 0x%02h",
						write_data, want.data));
				if (frame_done !== want.done)
					report_mismatch($sformatf("frame_done %b, expected %b",
						frame_done, want.done));
				if (last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run %b, expected %b",
						last_of_run, want.last));
				if (want.en)
					writes_seen++;
				else
					drops_seen++;
				if (want.done)
					frames_seen++;
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			predict_writes(sample);
			accepted_count++;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_IMAGE_WIDTH:   pic_width = val;
			CFG_IMAGE_HEIGHT:  pic_height = val;
			CFG_BLOCKS_ACROSS: blk_across = val[BLKS_W-1:0];
			CFG_BLOCKS_DOWN:   blk_down = val[BLKS_W-1:0];
			CFG_HORIZ_CELLS:   cells_h = val[CELL_W-1:0];
			CFG_VERT_CELLS:    cells_v = val[CELL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] ht,
		input logic [CFG_DATA_W-1:0] bx, input logic [CFG_DATA_W-1:0] by,
		input logic [CFG_DATA_W-1:0] hc, input logic [CFG_DATA_W-1:0] vc);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, ht);
		write_reg(CFG_BLOCKS_ACROSS, bx);
		write_reg(CFG_BLOCKS_DOWN, by);
		write_reg(CFG_HORIZ_CELLS, hc);
		write_reg(CFG_VERT_CELLS, vc);
		@(negedge clk);
		cfg_write <= 1'b0;
		config_count++;
	endtask

	task automatic feed(input int count);
		@(posedge clk);
		for (int i = 0; i < count; i++)
			sample_queue.push_back(DATA_W'($urandom_range(0, 255)));
		pushed_count += count;
	endtask

	// all samples taken and all writes seen, then let the block settle
	task automatic wait_idle();
		while (accepted_count != pushed_count || pending_writes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_dim();
		case ($urandom_range(0, 5))
			0: return 12'd8;
			1: return 12'd2048;
			2: return 12'hFFF;
			3: return CFG_DATA_W'($urandom);
			default: return CFG_DATA_W'($urandom_range(8, 2048));
		endcase
	endfunction

	// mostly tiny grids so frames wrap often
	function automatic logic [CFG_DATA_W-1:0] pick_blocks();
		case ($urandom_range(0, 7))
			0: return 12'd0;
			1: return 12'd1;
			2: return 12'd256;
			3: return 12'hFFF;
			default: return CFG_DATA_W'($urandom_range(1, 6));
		endcase
	endfunction

	initial begin : stimulus
		logic [DATA_W-1:0] corner_vals[8];
		int                phase_len;
		corner_vals = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
		pic_width  = RST_IMAGE_WIDTH;
		pic_height = RST_IMAGE_HEIGHT;
		blk_across = RST_BLOCKS_ACROSS;
		blk_down   = RST_BLOCKS_DOWN;
		cells_h    = RST_HORIZ_CELLS;
		cells_v    = RST_VERT_CELLS;
		pix_idx    = '0;
		blk_idx    = '0;
		org_x      = '0;
		org_y      = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// sample extremes at the reset configuration
		@(posedge clk);
		foreach (corner_vals[i])
			sample_queue.push_back(corner_vals[i]);
		pushed_count += 8;
		feed(12);
		// run through the luma cells and Cb, stop partway into the Cr block
		feed(310);
		wait_idle();

		// shrink the MCU mid Cr block: block index now past the MCU;
		// wide picture, zero and oversized block counts, cells of zero
		apply_config(12'hFFF, 12'hFFF, 12'd0, 12'h1FF, 12'd0, 12'd0);
		feed(250);
		wait_idle();

		// single-cell MCUs across a wide row move the origin out
		apply_config(12'd2048, 12'd8, 12'd256, 12'd2, 12'd1, 12'd1);
		feed(500);
		wait_idle();

		// origin now beyond the grid; two-row MCUs with 3 cells saturating
		apply_config(12'd8, 12'd2048, 12'd1, 12'd3, 12'd3, 12'd2);
		hold_go = 1'b1;
		feed(300);
		wait_idle();

		// sender pauses until every write is out, then resumes
		apply_config(12'd16, 12'd16, 12'd2, 12'd2, 12'd2, 12'd1);
		feed(150);
		wait_idle();
		feed(150);
		wait_idle();

		// random configurations and lengths
		while (pushed_count < RANDOM_TARGET - TAIL_ITEMS) begin
			idling_on = ($urandom_range(0, 4) != 0);
			apply_config(pick_dim(), pick_dim(), pick_blocks(), pick_blocks(),
				CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 3)));
			phase_len = $urandom_range(60, 300);
			feed(phase_len);
			wait_idle();
		end

		// closing stretch with no idling on either side
		idling_on = 1'b0;
		apply_config(pick_dim(), pick_dim(), pick_blocks(), pick_blocks(),
			CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 3)));
		feed(TAIL_ITEMS);
		wait_idle();

		$display("samples %0d, writes %0d, dropped chroma %0d, frames done %0d",
			accepted_count, writes_seen, drops_seen, frames_seen);
		$display("register settings %0d, mismatches %0d", config_count, error_count);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#6000000;
		$display("FAIL");
		$finish;
	end

endmodule
